@@ sv/stm_pkg.sv @@
// Shared types, register map and reset values of the sensor trigger to MIDI note block.
// No dependencies; used by every other file by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package stm_pkg;

  // Default widths of the sample and tick timer
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int TIMER_BITS_DEF  = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register widths
  localparam int INTERVAL_W = 16;
  localparam int THRESH_W   = 10;
  localparam int WINDOW_W   = 8;
  localparam int NOTE_W     = 7;
  localparam int CHAN_W     = 5;
  localparam int VEL_W      = 7;

  localparam int OUT_TDATA_W = 24;

  // Reset values of the registers
  localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 16'd350;
  localparam logic [THRESH_W-1:0]   ON_THRESHOLD_RST    = 10'd38;
  localparam logic [THRESH_W-1:0]   OFF_THRESHOLD_RST   = 10'd16;
  localparam logic [THRESH_W-1:0]   FULL_SCALE_RST      = 10'd775;
  localparam logic [INTERVAL_W-1:0] HOLDOFF_DELAY_RST   = 16'd1000;
  localparam logic [WINDOW_W-1:0]   WINDOW_LENGTH_RST   = 8'd10;
  localparam logic [NOTE_W-1:0]     NOTE_PITCH_RST      = 7'd60;
  localparam logic [CHAN_W-1:0]     CHAN_NUM_RST        = 5'd1;

  localparam logic [VEL_W-1:0]    VEL_MAX   = 7'd127;
  localparam logic [WINDOW_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_INTERVAL = 3'd0,
    REG_ON_THRESHOLD    = 3'd1,
    REG_OFF_THRESHOLD   = 3'd2,
    REG_FULL_SCALE      = 3'd3,
    REG_HOLDOFF_DELAY   = 3'd4,
    REG_WINDOW_LENGTH   = 3'd5,
    REG_NOTE_PITCH      = 3'd6,
    REG_CHAN_NUM        = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SOUND = 2'd1,
    PH_HOLD  = 2'd2
  } phase_t;

  typedef enum logic {
    EV_NOTE_ON  = 1'b0,
    EV_NOTE_OFF = 1'b1
  } event_kind_t;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_DIV   = 2'd1,
    ST_PUT   = 2'd2
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic tick_en;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ev_on;
    logic ev_off;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/stm_ctrl.sv @@
// Sequencing controller: accept a tick, run the velocity division, load the result item.
// Depends on stm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stm_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  stm_pkg::dp_stat_t stat,
  output stm_pkg::ctrl_cmd_t cmd,
  output stm_pkg::ctrl_state_t state
);

  stm_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stm_pkg::ST_READY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      stm_pkg::ST_READY: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.tick_en = 1'b1;
          if (stat.ev_on) begin
            state_next = stm_pkg::ST_DIV;
          end else if (stat.ev_off) begin
            state_next = stm_pkg::ST_PUT;
          end
        end
      end
      stm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = stm_pkg::ST_PUT;
        end
      end
      stm_pkg::ST_PUT: begin
        // wait for the output register to free up
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = stm_pkg::ST_READY;
        end
      end
      default: begin
        state_next = stm_pkg::ST_READY;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/stm_dp.sv @@
// Datapath: configuration registers, tick timer, phase, window peak, serial velocity
// divider and output register. Depends on stm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stm_dp #(
  parameter int SAMPLE_BITS = stm_pkg::SAMPLE_BITS_DEF,
  parameter int TIMER_BITS  = stm_pkg::TIMER_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire  [stm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [stm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire  [SAMPLE_BITS-1:0]            sample,
  input  stm_pkg::ctrl_cmd_t                cmd,
  output stm_pkg::dp_stat_t                 stat,
  input  wire                               out_ready,
  output logic                              out_valid,
  output logic                              out_kind,
  output logic [stm_pkg::NOTE_W-1:0]        out_note,
  output logic [stm_pkg::VEL_W-1:0]         out_vel,
  output logic [stm_pkg::CHAN_W-1:0]        out_chan
);

  localparam int TCW = (TIMER_BITS > stm_pkg::INTERVAL_W) ? TIMER_BITS : stm_pkg::INTERVAL_W;
  localparam int SCW = (SAMPLE_BITS > stm_pkg::THRESH_W) ? SAMPLE_BITS : stm_pkg::THRESH_W;
  localparam int DW  = SAMPLE_BITS + stm_pkg::VEL_W;
  localparam int FSW = stm_pkg::THRESH_W + stm_pkg::VEL_W;
  localparam int QW  = (DW > FSW) ? DW : FSW;
  localparam int SIW = $clog2(stm_pkg::VEL_W);

  // configuration registers
  logic [stm_pkg::INTERVAL_W-1:0] sample_interval;
  logic [stm_pkg::THRESH_W-1:0]   on_threshold;
  logic [stm_pkg::THRESH_W-1:0]   off_threshold;
  logic [stm_pkg::THRESH_W-1:0]   full_scale;
  logic [stm_pkg::INTERVAL_W-1:0] holdoff_delay;
  logic [stm_pkg::WINDOW_W-1:0]   window_length;
  logic [stm_pkg::NOTE_W-1:0]     note_pitch;
  logic [stm_pkg::CHAN_W-1:0]     chan_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= stm_pkg::SAMPLE_INTERVAL_RST;
      on_threshold    <= stm_pkg::ON_THRESHOLD_RST;
      off_threshold   <= stm_pkg::OFF_THRESHOLD_RST;
      full_scale      <= stm_pkg::FULL_SCALE_RST;
      holdoff_delay   <= stm_pkg::HOLDOFF_DELAY_RST;
      window_length   <= stm_pkg::WINDOW_LENGTH_RST;
      note_pitch      <= stm_pkg::NOTE_PITCH_RST;
      chan_num        <= stm_pkg::CHAN_NUM_RST;
    end else if (cfg_we) begin
      unique case (stm_pkg::reg_index_t'(cfg_index))
        stm_pkg::REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[stm_pkg::INTERVAL_W-1:0];
        stm_pkg::REG_ON_THRESHOLD:    on_threshold    <= cfg_data[stm_pkg::THRESH_W-1:0];
        stm_pkg::REG_OFF_THRESHOLD:   off_threshold   <= cfg_data[stm_pkg::THRESH_W-1:0];
        stm_pkg::REG_FULL_SCALE:      full_scale      <= cfg_data[stm_pkg::THRESH_W-1:0];
        stm_pkg::REG_HOLDOFF_DELAY:   holdoff_delay   <= cfg_data[stm_pkg::INTERVAL_W-1:0];
        stm_pkg::REG_WINDOW_LENGTH:   window_length   <= cfg_data[stm_pkg::WINDOW_W-1:0];
        stm_pkg::REG_NOTE_PITCH:      note_pitch      <= cfg_data[stm_pkg::NOTE_W-1:0];
        stm_pkg::REG_CHAN_NUM:        chan_num        <= cfg_data[stm_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // tick state
  stm_pkg::phase_t               phase, phase_next;
  logic [TIMER_BITS-1:0]         tick_timer, tick_timer_next, timer_inc;
  logic [SAMPLE_BITS-1:0]        window_peak, window_peak_next, peak_fold;
  logic [stm_pkg::WINDOW_W-1:0]  window_count, window_count_next, count_inc;
  logic                          due, ev_on, ev_off;

  always_comb begin
    timer_inc = (&tick_timer) ? tick_timer : tick_timer + 1'b1;
    due       = TCW'(timer_inc) >= TCW'(sample_interval);
    count_inc = (window_count < stm_pkg::COUNT_MAX) ? window_count + 1'b1 : window_count;
    peak_fold = (sample > window_peak) ? sample : window_peak;

    phase_next        = phase;
    tick_timer_next   = timer_inc;
    window_peak_next  = window_peak;
    window_count_next = window_count;
    ev_on             = 1'b0;
    ev_off            = 1'b0;

    unique case (phase)
      stm_pkg::PH_SOUND: begin
        if (due) begin
          tick_timer_next = '0;
          if (count_inc >= window_length) begin
            window_count_next = '0;
            window_peak_next  = '0;
            if (SCW'(peak_fold) <= SCW'(off_threshold)) begin
              phase_next = stm_pkg::PH_HOLD;
              ev_off     = 1'b1;
            end
          end else begin
            window_count_next = count_inc;
            window_peak_next  = peak_fold;
          end
        end
      end
      stm_pkg::PH_HOLD: begin
        if (TCW'(timer_inc) >= TCW'(holdoff_delay)) begin
          phase_next = stm_pkg::PH_IDLE;
        end
      end
      default: begin
        // idle, and any unused code behaves as idle
        phase_next = stm_pkg::PH_IDLE;
        if (due) begin
          tick_timer_next = '0;
          if (SCW'(sample) >= SCW'(on_threshold)) begin
            phase_next        = stm_pkg::PH_SOUND;
            window_count_next = stm_pkg::WINDOW_W'(1);
            window_peak_next  = '0;
            ev_on             = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= stm_pkg::PH_IDLE;
      tick_timer   <= '0;
      window_peak  <= '0;
      window_count <= '0;
    end else if (cmd.tick_en) begin
      phase        <= phase_next;
      tick_timer   <= tick_timer_next;
      window_peak  <= window_peak_next;
      window_count <= window_count_next;
    end
  end

  // velocity = min(127, sample*127/full_scale), restoring division one bit a cycle
  logic [DW-1:0]            product;
  logic [QW-1:0]            fs_top, div_rem, div_sub;
  logic                     sat, div_hit;
  logic [stm_pkg::VEL_W-1:0] quot;
  logic [SIW-1:0]           step_idx;
  logic                     ev_kind;

  always_comb begin
    product = {sample, stm_pkg::VEL_W'(0)} - DW'(sample);
    fs_top  = QW'({full_scale, stm_pkg::VEL_W'(0)});
    sat     = QW'(product) >= fs_top;
    div_sub = QW'(full_scale) << step_idx;
    div_hit = div_rem >= div_sub;
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_en) begin
      ev_kind  <= ev_off;
      step_idx <= SIW'(stm_pkg::VEL_W - 1);
      if (sat) begin
        quot    <= stm_pkg::VEL_MAX;
        div_rem <= '0;
      end else begin
        quot    <= '0;
        div_rem <= QW'(product);
      end
    end else if (cmd.div_step) begin
      if (div_hit) begin
        quot[step_idx] <= 1'b1;
        div_rem        <= div_rem - div_sub;
      end
      step_idx <= step_idx - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind <= ev_kind;
      out_note <= note_pitch;
      out_vel  <= (ev_kind == stm_pkg::EV_NOTE_OFF) ? '0 : quot;
      out_chan <= chan_num;
    end
  end

  always_comb begin
    stat.ev_on    = ev_on;
    stat.ev_off   = ev_off;
    stat.div_last = (step_idx == '0);
    stat.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

@@ sv/sensor_trigger_to_midi_note.sv @@
// Top level of the sensor trigger to MIDI note block: stream ports and assertions.
// Depends on stm_pkg, stm_ctrl and stm_dp.
`timescale 1ns / 1ps
`default_nettype none
// Each input item is one microsecond tick carrying the current converter sample. A
// saturating tick timer decides when the sensor is sampled; while idle a sample at or above
// on_threshold sends note on with velocity min(127, sample*127/full_scale), while sounding the
// peak of each window of samples is kept and a window peak at or below off_threshold sends
// note off, after which holdoff_delay ticks pass before the block rearms. A tick that sends
// nothing is taken in the ready state alone; a note-off tick then passes the put state, which
// loads the output register; a note-on tick first runs a restoring divider one quotient bit
// per cycle in the divide state, then the put state, before the next item is taken.
// Results sit in an output register, so ticks keep flowing while a result waits; only a
// second result stalls input, in its load cycle, until the first one is taken.
// Configuration is a plain write port (index per register list, no read-back).
module sensor_trigger_to_midi_note #(
  parameter int SAMPLE_BITS = stm_pkg::SAMPLE_BITS_DEF,
  parameter int TIMER_BITS  = stm_pkg::TIMER_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  // configuration write port
  input  wire                                cfg_we,
  input  wire  [stm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [stm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // tick stream
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,   // adc_sample
  // MIDI event stream
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [stm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // note_number, note_velocity,
                                                             // channel_number, zero fill
  output logic                               m_axis_tuser    // event_kind
);

  stm_pkg::ctrl_cmd_t   cmd;
  stm_pkg::dp_stat_t    stat;
  stm_pkg::ctrl_state_t ctrl_state;

  logic                         ev_kind;
  logic [stm_pkg::NOTE_W-1:0]   ev_note;
  logic [stm_pkg::VEL_W-1:0]    ev_vel;
  logic [stm_pkg::CHAN_W-1:0]   ev_chan;

  stm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (ctrl_state)
  );

  stm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_kind  (ev_kind),
    .out_note  (ev_note),
    .out_vel   (ev_vel),
    .out_chan  (ev_chan)
  );

  // pack the event fields from the lowest bit up, zero fill to whole bytes
  assign m_axis_tdata = stm_pkg::OUT_TDATA_W'({ev_chan, ev_vel, ev_note});
  assign m_axis_tuser = ev_kind;

  // no new tick is taken while the divider is busy
  a_busy_no_ready : assert property (@(posedge clk) disable iff (rst)
    (ctrl_state == stm_pkg::ST_DIV) |-> !s_axis_tready)
    else $error("tick taken while the velocity divider is busy");

  // a note-on tick starts the divider in the next cycle
  a_on_starts_div : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && stat.ev_on) |=> (ctrl_state == stm_pkg::ST_DIV))
    else $error("note on did not start the divider");

  // note off always carries zero velocity
  a_off_zero_vel : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (ev_vel == '0))
    else $error("note off with nonzero velocity");

endmodule
`default_nettype wire
